/* rtl/core/direct_mapped_cache_hit_tracker_core_macros.svh */
// Assertion helpers for the cache hit tracker.
`ifndef DIRECT_MAPPED_CACHE_HIT_TRACKER_CORE_MACROS_SVH
`define DIRECT_MAPPED_CACHE_HIT_TRACKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define DMCT_ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DMCT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DMCT_ASSERT_PROP(label, clk, rst_n, prop, msg)

`define DMCT_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/core/dmct_pkg.sv */
`default_nettype none

package dmct_pkg;

    localparam int ADDR_W          = 32;
    localparam int EXT_W           = 64;
    localparam int COUNT_W         = 32;
    localparam int INDEX_BITS_DEF  = 11;
    localparam int OFFSET_BITS_DEF = 6;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic valid;
        logic hit;
    } dmct_item_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dmct_access_if.sv */
`default_nettype none

interface dmct_access_if;
    logic                        valid;
    logic                        ready;
    logic [dmct_pkg::ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

/* rtl/core/dmct_result_if.sv */
`default_nettype none

interface dmct_result_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [dmct_pkg::COUNT_W-1:0] access_count;
    logic [dmct_pkg::COUNT_W-1:0] miss_count;

    modport source (output valid, output hit, output access_count, output miss_count,
                    input ready);
    modport sink   (input valid, input hit, input access_count, input miss_count,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/dmct_front.sv */
`default_nettype none

`include "direct_mapped_cache_hit_tracker_core_macros.svh"

module dmct_front #(
    parameter int INDEX_BITS  = dmct_pkg::INDEX_BITS_DEF,
    parameter int OFFSET_BITS = dmct_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = dmct_pkg::ADDR_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    dmct_access_if.sink         access,
    output dmct_pkg::dmct_item_t push,
    input  wire logic           q_full
);

    localparam int TAG_SHIFT = OFFSET_BITS + INDEX_BITS;
    localparam bit HAS_TAG   = (ADDR_BITS > TAG_SHIFT);
    localparam int TAG_W     = HAS_TAG ? (ADDR_BITS - TAG_SHIFT) : 1;
    localparam int ENTRY_W   = TAG_W + 1;
    localparam int LINES     = 1 << INDEX_BITS;
    localparam logic [INDEX_BITS-1:0] LAST_IDX = {INDEX_BITS{1'b1}};

    // entry = {valid, tag}
    logic [ENTRY_W-1:0] mem [LINES];

    logic [dmct_pkg::EXT_W-1:0] addr_ext;
    logic [dmct_pkg::EXT_W-1:0] addr_shift;
    logic [INDEX_BITS-1:0]      in_idx;
    logic [TAG_W-1:0]           in_tag;
    logic                       in_fire;

    logic                  clearing_reg;
    logic [INDEX_BITS-1:0] clr_idx_reg;
    logic                  s2_valid_reg;
    logic                  s2_valid_next;
    logic [INDEX_BITS-1:0] s2_idx_reg;
    logic [TAG_W-1:0]      s2_tag_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  fwd_valid_reg;
    logic [INDEX_BITS-1:0] fwd_idx_reg;
    logic [TAG_W-1:0]      fwd_tag_reg;

    logic                  s2_adv;
    logic                  use_fwd;
    logic                  line_valid;
    logic [TAG_W-1:0]      line_tag;
    logic                  hit;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;

    assign addr_ext   = {{(dmct_pkg::EXT_W - dmct_pkg::ADDR_W){1'b0}}, access.address};
    assign addr_shift = addr_ext >> TAG_SHIFT;
    assign in_idx     = addr_ext[OFFSET_BITS +: INDEX_BITS];
    assign in_tag     = HAS_TAG ? addr_shift[TAG_W-1:0] : '0;

    assign s2_adv       = s2_valid_reg && !q_full;
    assign access.ready = !clearing_reg && (!s2_valid_reg || !q_full);
    assign in_fire      = access.valid && access.ready;

    // last item to leave stage 2 owns the newest copy of its line
    assign use_fwd    = fwd_valid_reg && (fwd_idx_reg == s2_idx_reg);
    assign line_valid = use_fwd || rd_data_reg[TAG_W];
    assign line_tag   = use_fwd ? fwd_tag_reg : rd_data_reg[TAG_W-1:0];
    assign hit        = line_valid && (line_tag == s2_tag_reg);

    assign mem_we    = clearing_reg || (s2_adv && !hit);
    assign mem_waddr = clearing_reg ? clr_idx_reg : s2_idx_reg;
    assign mem_wdata = clearing_reg ? '0 : {1'b1, s2_tag_reg};

    assign push.valid = s2_adv;
    assign push.hit   = hit;

    always_comb
    begin
        if (in_fire)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire)
        begin
            rd_data_reg <= mem[in_idx];
            s2_idx_reg  <= in_idx;
            s2_tag_reg  <= in_tag;
        end
        if (s2_adv)
        begin
            fwd_idx_reg <= s2_idx_reg;
            fwd_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + INDEX_BITS'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            s2_valid_reg <= s2_valid_next;
            if (s2_adv)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    `DMCT_ASSERT_NEVER(a_no_accept_while_clearing, clk, rst_n, in_fire && clearing_reg,
        "access taken during clear pass")
    `DMCT_ASSERT_PROP(a_accept_loads_stage, clk, rst_n, in_fire |=> s2_valid_reg,
        "accepted access lost before classify")
    `DMCT_ASSERT_PROP(a_clear_covers_all, clk, rst_n,
        $fell(clearing_reg) |-> ($past(clr_idx_reg) == LAST_IDX),
        "clear pass ended early")

endmodule

`default_nettype wire

/* rtl/core/dmct_queue.sv */
`default_nettype none

`include "direct_mapped_cache_hit_tracker_core_macros.svh"

module dmct_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dmct_pkg::dmct_item_t push,
    output logic                      full,
    output dmct_pkg::dmct_item_t      head,
    input  wire logic                 pop
);

    localparam int DEPTH = dmct_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic             data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.hit   = data_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        unique case ({push.valid, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            data_reg[wr_ptr_reg] <= push.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `DMCT_ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push.valid && full,
        "push into full queue")
    `DMCT_ASSERT_NEVER(a_count_in_range, clk, rst_n, count_reg > CNT_W'(DEPTH),
        "queue count out of range")

endmodule

`default_nettype wire

/* rtl/core/dmct_back.sv */
`default_nettype none

module dmct_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dmct_pkg::dmct_item_t head,
    output logic                      pop,
    dmct_result_if.source             result
);

    logic                         out_valid_reg;
    logic                         hit_reg;
    logic [dmct_pkg::COUNT_W-1:0] acc_reg;
    logic [dmct_pkg::COUNT_W-1:0] miss_reg;
    logic [dmct_pkg::COUNT_W-1:0] acc_next;
    logic [dmct_pkg::COUNT_W-1:0] miss_next;

    assign pop = head.valid && (!out_valid_reg || result.ready);

    assign acc_next  = dmct_pkg::sat_inc(acc_reg);
    assign miss_next = head.hit ? miss_reg : dmct_pkg::sat_inc(miss_reg);

    assign result.valid        = out_valid_reg;
    assign result.hit          = hit_reg;
    assign result.access_count = acc_reg;
    assign result.miss_count   = miss_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hit_reg <= head.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            miss_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                miss_reg      <= miss_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/direct_mapped_cache_hit_tracker_core.sv */
// Path: an access is held in stage 2, queued, then popped into the result registers.
// Throughput: one access per cycle while the queue is not full; tag read and update use
// separate read and write ports of the tag store, with the last update forwarded to the compare.
// Reset: async active low; counters clear at once, then a clear pass over all
// 2^INDEX_BITS lines (2048 by default) zeroes the tag store, no access taken.
`default_nettype none

module direct_mapped_cache_hit_tracker_core #(
    parameter int INDEX_BITS  = dmct_pkg::INDEX_BITS_DEF,
    parameter int OFFSET_BITS = dmct_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = dmct_pkg::ADDR_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dmct_access_if.sink   access,
    dmct_result_if.source result
);

    dmct_pkg::dmct_item_t push;
    dmct_pkg::dmct_item_t head;
    logic                 q_full;
    logic                 pop;

    dmct_front #(
        .INDEX_BITS  (INDEX_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (access),
        .push   (push),
        .q_full (q_full)
    );

    dmct_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    dmct_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire
